@@ src/rres_pkg.sv @@
// ----------------------------------------------------------------------------
// rres_pkg
// shared constants, types and helpers of the raster resampler
// ----------------------------------------------------------------------------
package rres_pkg;

	// raster store geometry
	localparam int MAX_ROWS    = 256;
	localparam int MAX_COLUMNS = 256;
	localparam int MAX_BANDS   = 2;
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int BAND_W      = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLUMNS * MAX_BANDS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	// field widths
	localparam int POS_W    = 40;
	localparam int CS_W     = 39;
	localparam int CNT_W    = 9;
	localparam int BCNT_W   = 2;
	localparam int SAMPLE_W = 32;
	localparam int FRAC     = 16;
	localparam int QUO_W    = POS_W + FRAC;
	localparam int SEQ_W    = $clog2(QUO_W);
	localparam int T_W      = FRAC + 2;

	// arithmetic widths
	localparam int W_W     = 21;
	localparam int PROD_W  = W_W + SAMPLE_W;
	localparam int LINE_W  = PROD_W + 2;
	localparam int OPROD_W = W_W + LINE_W;
	localparam int ACC_W   = OPROD_W + 2;

	// configuration port
	localparam int PADDR_W = 6;
	localparam int PDATA_W = 64;

	localparam logic [1:0] MODE_NEAREST  = 2'd0;
	localparam logic [1:0] MODE_BILINEAR = 2'd1;
	localparam logic OP_WRITE = 1'b0;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_CELL_SIZE,
		REG_ROW_COUNT,
		REG_COLUMN_COUNT,
		REG_BAND_COUNT,
		REG_NODATA_VALUE
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]                 mode;
		logic signed [POS_W-1:0]    origin_x;
		logic signed [POS_W-1:0]    origin_y;
		logic [CS_W-1:0]            cell_size;
		logic [CNT_W-1:0]           row_count;
		logic [CNT_W-1:0]           column_count;
		logic [BCNT_W-1:0]          band_count;
		logic signed [SAMPLE_W-1:0] nodata_value;
		// effective values after range fixing
		logic [CS_W-1:0]            cs_eff;
		logic [CNT_W-1:0]           rows_eff;
		logic [CNT_W-1:0]           cols_eff;
		logic [BCNT_W-1:0]          bands_eff;
	} cfg_t;

	typedef enum logic [1:0] {
		RES_ZERO,
		RES_NODATA,
		RES_CENTER,
		RES_BLEND
	} res_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRITE,
		ST_EVAL,
		ST_DIV,
		ST_CHECK,
		ST_CENTER,
		ST_WGT,
		ST_TAPS,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic       load;
		logic       mem_wr;
		logic       div_start;
		logic       div_step;
		logic       rd_center;
		logic       blend_init;
		logic       wgt_issue;
		logic       tap_issue;
		logic [3:0] idx;
		logic       fin;
		logic       clamp_flag;
		res_sel_t   sel;
	} cmd_t;

	typedef struct packed {
		logic early_nd;
		logic oob;
		logic nearest;
		logic bilinear;
	} sts_t;

	function automatic logic [ADDR_W-1:0] store_addr(
		input logic [ROW_W-1:0]  row,
		input logic [COL_W-1:0]  col,
		input logic [BAND_W-1:0] band
	);
		return ADDR_W'((int'(row) * MAX_COLUMNS + int'(col)) * MAX_BANDS + int'(band));
	endfunction

endpackage

@@ src/rres_cfg.sv @@
// ----------------------------------------------------------------------------
// rres_cfg
// register file behind the configuration port
// ----------------------------------------------------------------------------
module rres_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rres_pkg::PADDR_W-1:0]    paddr,
	input  logic [rres_pkg::PDATA_W-1:0]    pwdata,
	output logic [rres_pkg::PDATA_W-1:0]    prdata,
	output rres_pkg::cfg_t                  cfg
);
	import rres_pkg::*;

	logic [1:0]                 mode_q;
	logic signed [POS_W-1:0]    origin_x_q;
	logic signed [POS_W-1:0]    origin_y_q;
	logic [CS_W-1:0]            cell_size_q;
	logic [CNT_W-1:0]           row_count_q;
	logic [CNT_W-1:0]           column_count_q;
	logic [BCNT_W-1:0]          band_count_q;
	logic signed [SAMPLE_W-1:0] nodata_q;
	reg_idx_t                   idx;
	logic                       wr_en;

	assign idx   = reg_idx_t'(paddr[PADDR_W-1:3]);
	assign wr_en = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 2'd2;
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			cell_size_q    <= CS_W'(64'd268435456);
			row_count_q    <= CNT_W'(256);
			column_count_q <= CNT_W'(256);
			band_count_q   <= BCNT_W'(1);
			nodata_q       <= SAMPLE_W'(-8388608);
		end else if (wr_en) begin
			case (idx)
				REG_MODE:         mode_q         <= pwdata[1:0];
				REG_ORIGIN_X:     origin_x_q     <= pwdata[POS_W-1:0];
				REG_ORIGIN_Y:     origin_y_q     <= pwdata[POS_W-1:0];
				REG_CELL_SIZE:    cell_size_q    <= pwdata[CS_W-1:0];
				REG_ROW_COUNT:    row_count_q    <= pwdata[CNT_W-1:0];
				REG_COLUMN_COUNT: column_count_q <= pwdata[CNT_W-1:0];
				REG_BAND_COUNT:   band_count_q   <= pwdata[BCNT_W-1:0];
				REG_NODATA_VALUE: nodata_q       <= pwdata[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MODE:         prdata = PDATA_W'(mode_q);
			REG_ORIGIN_X:     prdata = PDATA_W'(unsigned'(origin_x_q));
			REG_ORIGIN_Y:     prdata = PDATA_W'(unsigned'(origin_y_q));
			REG_CELL_SIZE:    prdata = PDATA_W'(cell_size_q);
			REG_ROW_COUNT:    prdata = PDATA_W'(row_count_q);
			REG_COLUMN_COUNT: prdata = PDATA_W'(column_count_q);
			REG_BAND_COUNT:   prdata = PDATA_W'(band_count_q);
			REG_NODATA_VALUE: prdata = PDATA_W'(unsigned'(nodata_q));
			default:          prdata = '0;
		endcase
	end

	always_comb begin
		cfg.mode         = mode_q;
		cfg.origin_x     = origin_x_q;
		cfg.origin_y     = origin_y_q;
		cfg.cell_size    = cell_size_q;
		cfg.row_count    = row_count_q;
		cfg.column_count = column_count_q;
		cfg.band_count   = band_count_q;
		cfg.nodata_value = nodata_q;
		cfg.cs_eff       = (cell_size_q == '0) ? CS_W'(1) : cell_size_q;
		if (row_count_q == '0)
			cfg.rows_eff = CNT_W'(1);
		else if (row_count_q > CNT_W'(MAX_ROWS))
			cfg.rows_eff = CNT_W'(MAX_ROWS);
		else
			cfg.rows_eff = row_count_q;
		if (column_count_q == '0)
			cfg.cols_eff = CNT_W'(1);
		else if (column_count_q > CNT_W'(MAX_COLUMNS))
			cfg.cols_eff = CNT_W'(MAX_COLUMNS);
		else
			cfg.cols_eff = column_count_q;
		if (band_count_q == '0)
			cfg.bands_eff = BCNT_W'(1);
		else if (band_count_q > BCNT_W'(MAX_BANDS))
			cfg.bands_eff = BCNT_W'(MAX_BANDS);
		else
			cfg.bands_eff = band_count_q;
	end

endmodule

@@ src/rres_div.sv @@
// ----------------------------------------------------------------------------
// rres_div
// restoring divider, one quotient bit per step, integer and fraction bits
// ----------------------------------------------------------------------------
module rres_div (
	input  logic                          clk,
	input  logic                          init,
	input  logic                          step,
	input  logic [rres_pkg::POS_W-1:0]    dividend,
	input  logic [rres_pkg::CS_W-1:0]     divisor,
	output logic [rres_pkg::QUO_W-1:0]    quotient
);
	import rres_pkg::*;

	logic [CS_W-1:0]  rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [CS_W:0]    trial;
	logic             fits;

	// shift register holds the remaining dividend bits and collects quotient bits
	assign trial = {rem_q, quo_q[QUO_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		if (init) begin
			rem_q <= '0;
			quo_q <= {dividend, {FRAC{1'b0}}};
		end else if (step) begin
			rem_q <= fits ? CS_W'(trial - {1'b0, divisor}) : trial[CS_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	assign quotient = quo_q;

endmodule

@@ src/rres_ctrl.sv @@
// ----------------------------------------------------------------------------
// rres_ctrl
// sequencer: sample write, or divide, center fetch, weight build, tap sweep, result
// ----------------------------------------------------------------------------
module rres_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            operation,
	input  rres_pkg::sts_t  sts,
	output rres_pkg::cmd_t  cmd,
	output logic            busy
);
	import rres_pkg::*;

	localparam logic [SEQ_W-1:0] DIV_LAST   = SEQ_W'(QUO_W - 1);
	localparam logic [SEQ_W-1:0] WGT_COUNT  = SEQ_W'(8);
	localparam logic [SEQ_W-1:0] WGT_LAST   = SEQ_W'(10);
	localparam logic [SEQ_W-1:0] BIC_LAST   = SEQ_W'(15);
	localparam logic [SEQ_W-1:0] BIL_LAST   = SEQ_W'(3);
	localparam logic [SEQ_W-1:0] DRAIN_LAST = SEQ_W'(4);

	state_t           state_q, state_d;
	logic [SEQ_W-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.sel = RES_ZERO;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = (operation == OP_WRITE) ? ST_WRITE : ST_EVAL;
				end
			end
			ST_WRITE: begin
				cmd.mem_wr = 1'b1;
				cmd.fin    = 1'b1;
				cmd.sel    = RES_ZERO;
				state_d    = ST_IDLE;
			end
			ST_EVAL: begin
				if (sts.early_nd) begin
					cmd.fin = 1'b1;
					cmd.sel = RES_NODATA;
					state_d = ST_IDLE;
				end else begin
					cmd.div_start = 1'b1;
					cnt_d         = '0;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_LAST)
					state_d = ST_CHECK;
				else
					cnt_d = cnt_q + 1'b1;
			end
			ST_CHECK: begin
				if (sts.nearest && sts.oob) begin
					cmd.fin = 1'b1;
					cmd.sel = RES_NODATA;
					state_d = ST_IDLE;
				end else begin
					cmd.rd_center = 1'b1;
					state_d       = ST_CENTER;
				end
			end
			ST_CENTER: begin
				if (sts.nearest || sts.oob) begin
					cmd.fin        = 1'b1;
					cmd.sel        = RES_CENTER;
					cmd.clamp_flag = sts.oob;
					state_d        = ST_IDLE;
				end else begin
					cmd.blend_init = 1'b1;
					cnt_d          = '0;
					state_d        = ST_WGT;
				end
			end
			ST_WGT: begin
				cmd.wgt_issue = cnt_q < WGT_COUNT;
				cmd.idx       = cnt_q[3:0];
				if (cnt_q == WGT_LAST) begin
					cnt_d   = '0;
					state_d = ST_TAPS;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_TAPS: begin
				cmd.tap_issue = 1'b1;
				cmd.idx       = cnt_q[3:0];
				if (cnt_q == (sts.bilinear ? BIL_LAST : BIC_LAST)) begin
					cnt_d   = '0;
					state_d = ST_DRAIN;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_DRAIN: begin
				if (cnt_q == DRAIN_LAST) begin
					cmd.fin = 1'b1;
					cmd.sel = RES_BLEND;
					state_d = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = state_q != ST_IDLE;

endmodule

@@ src/rres_dpath.sv @@
// ----------------------------------------------------------------------------
// rres_dpath
// raster store, cell mapping dividers, kernel weights, tap mac and result
// ----------------------------------------------------------------------------
module rres_dpath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rres_pkg::cfg_t                       cfg,
	input  rres_pkg::cmd_t                       cmd,
	output rres_pkg::sts_t                       sts,
	input  logic [rres_pkg::ROW_W-1:0]           write_row,
	input  logic [rres_pkg::COL_W-1:0]           write_column,
	input  logic [rres_pkg::BAND_W-1:0]          band_index,
	input  logic signed [rres_pkg::SAMPLE_W-1:0] write_value,
	input  logic signed [rres_pkg::POS_W-1:0]    position_x,
	input  logic signed [rres_pkg::POS_W-1:0]    position_y,
	output logic                                 done,
	output logic signed [rres_pkg::SAMPLE_W-1:0] result_value,
	output logic                                 no_data,
	output logic                                 edge_clamped
);
	import rres_pkg::*;

	localparam logic [T_W-1:0] ONE_T = T_W'(1) << FRAC;

	// captured item
	logic [ROW_W-1:0]           wrow_q;
	logic [COL_W-1:0]           wcol_q;
	logic [BAND_W-1:0]          band_q;
	logic signed [SAMPLE_W-1:0] wval_q;
	logic signed [POS_W:0]      dx_q, dy_q;

	// mode decode
	logic bicubic, bilinear, nearest;
	assign bicubic  = cfg.mode[1];
	assign bilinear = cfg.mode == MODE_BILINEAR;
	assign nearest  = cfg.mode == MODE_NEAREST;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wrow_q <= write_row;
			wcol_q <= write_column;
			band_q <= band_index;
			wval_q <= write_value;
			dx_q   <= (POS_W+1)'(position_x) - (POS_W+1)'(cfg.origin_x);
			dy_q   <= (POS_W+1)'(cfg.origin_y) - (POS_W+1)'(position_y);
		end
	end

	// cell mapping, x and y in parallel
	logic [QUO_W-1:0] qx, qy;

	rres_div u_div_x (
		.clk      (clk),
		.init     (cmd.div_start),
		.step     (cmd.div_step),
		.dividend (dx_q[POS_W-1:0]),
		.divisor  (cfg.cs_eff),
		.quotient (qx)
	);

	rres_div u_div_y (
		.clk      (clk),
		.init     (cmd.div_start),
		.step     (cmd.div_step),
		.dividend (dy_q[POS_W-1:0]),
		.divisor  (cfg.cs_eff),
		.quotient (qy)
	);

	logic             row_oob, col_oob;
	logic [ROW_W-1:0] row_c, rows_last;
	logic [COL_W-1:0] col_c, cols_last;
	logic [FRAC-1:0]  frac_u, frac_v;

	assign row_oob   = qy[QUO_W-1:FRAC] >= POS_W'(cfg.rows_eff);
	assign col_oob   = qx[QUO_W-1:FRAC] >= POS_W'(cfg.cols_eff);
	assign rows_last = ROW_W'(cfg.rows_eff - 1'b1);
	assign cols_last = COL_W'(cfg.cols_eff - 1'b1);
	assign row_c     = row_oob ? rows_last : qy[FRAC+ROW_W-1:FRAC];
	assign col_c     = col_oob ? cols_last : qx[FRAC+COL_W-1:FRAC];
	assign frac_u    = qx[FRAC-1:0];
	assign frac_v    = qy[FRAC-1:0];

	assign sts.early_nd = dx_q[POS_W] | dy_q[POS_W] |
		(BCNT_W'(band_q) >= cfg.bands_eff);
	assign sts.oob      = row_oob | col_oob;
	assign sts.nearest  = nearest;
	assign sts.bilinear = bilinear;

	// tap address decode
	logic [1:0]       tap_i, tap_j;
	logic             tap_last, tap_oob;
	logic [ROW_W+1:0] tap_row;
	logic [COL_W+1:0] tap_col;
	logic [1:0]       tap_off;

	always_comb begin
		if (bilinear) begin
			tap_i    = {1'b0, cmd.idx[0]};
			tap_j    = {1'b0, cmd.idx[1]};
			tap_last = cmd.idx[0];
			tap_off  = 2'd0;
		end else begin
			tap_i    = cmd.idx[1:0];
			tap_j    = cmd.idx[3:2];
			tap_last = cmd.idx[1:0] == 2'd3;
			tap_off  = 2'd1;
		end
		tap_row = (ROW_W+2)'(row_c) + (ROW_W+2)'(tap_j) - (ROW_W+2)'(tap_off);
		tap_col = (COL_W+2)'(col_c) + (COL_W+2)'(tap_i) - (COL_W+2)'(tap_off);
		// negative offsets wrap to large values and land out of range
		tap_oob = (tap_row >= (ROW_W+2)'(cfg.rows_eff)) ||
			(tap_col >= (COL_W+2)'(cfg.cols_eff));
	end

	// raster store
	logic signed [SAMPLE_W-1:0] mem [STORE_DEPTH];
	logic signed [SAMPLE_W-1:0] mem_q;
	logic [ADDR_W-1:0]          rd_addr, wr_addr;
	logic                       wr_ok;

	assign wr_ok = (CNT_W'(wrow_q) < cfg.rows_eff) && (CNT_W'(wcol_q) < cfg.cols_eff) &&
		(BCNT_W'(band_q) < cfg.bands_eff);
	assign wr_addr = store_addr(wrow_q, wcol_q, band_q);
	assign rd_addr = cmd.tap_issue ?
		store_addr(tap_row[ROW_W-1:0], tap_col[COL_W-1:0], band_q) :
		store_addr(row_c, col_c, band_q);

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && wr_ok)
			mem[wr_addr] <= wval_q;
		if (cmd.rd_center || cmd.tap_issue)
			mem_q <= mem[rd_addr];
	end

	// kernel weight pipe: t, t^2, t^3, then the piecewise cubic
	logic [FRAC-1:0]        wa;
	logic [T_W-1:0]         t_in;
	logic [FRAC:0]          bw_in;
	logic                   wv_s1, wv_s2, wv_s3;
	logic [2:0]             widx_s1, widx_s2, widx_s3;
	logic [T_W-1:0]         t_s1, t_s2, t_s3;
	logic [FRAC:0]          bw_s1, bw_s2, bw_s3;
	logic [T_W+1:0]         t2_s2, t2_s3;
	logic [T_W+3:0]         t3_s3;
	logic [2*T_W-1:0]       sq;
	logic [2*T_W+1:0]       cube;
	logic signed [T_W+7:0]  kw;
	logic signed [W_W-1:0]  wnew;
	logic signed [W_W-1:0]  wx_q [4];
	logic signed [W_W-1:0]  wy_q [4];

	always_comb begin
		wa = cmd.idx[2] ? frac_v : frac_u;
		case (cmd.idx[1:0])
			2'd0:    t_in = T_W'(wa) + ONE_T;
			2'd1:    t_in = T_W'(wa);
			2'd2:    t_in = ONE_T - T_W'(wa);
			default: t_in = (ONE_T << 1) - T_W'(wa);
		endcase
		case (cmd.idx[1:0])
			2'd0:    bw_in = (FRAC+1)'(ONE_T) - (FRAC+1)'(wa);
			2'd1:    bw_in = (FRAC+1)'(wa);
			default: bw_in = '0;
		endcase
	end

	assign sq   = t_s1 * t_s1;
	assign cube = t2_s2 * t_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wv_s1 <= 1'b0;
			wv_s2 <= 1'b0;
			wv_s3 <= 1'b0;
		end else begin
			wv_s1 <= cmd.wgt_issue;
			wv_s2 <= wv_s1;
			wv_s3 <= wv_s2;
		end
	end

	always_ff @(posedge clk) begin
		t_s1    <= t_in;
		bw_s1   <= bw_in;
		widx_s1 <= cmd.idx[2:0];
		t2_s2   <= (T_W+2)'(sq >> FRAC);
		t_s2    <= t_s1;
		bw_s2   <= bw_s1;
		widx_s2 <= widx_s1;
		t3_s3   <= (T_W+4)'(cube >> FRAC);
		t2_s3   <= t2_s2;
		t_s3    <= t_s2;
		bw_s3   <= bw_s2;
		widx_s3 <= widx_s2;
	end

	always_comb begin
		if (t_s3 <= ONE_T)
			kw = $signed((T_W+8)'(t3_s3)) - ($signed((T_W+8)'(t2_s3)) <<< 1) +
				$signed((T_W+8)'(ONE_T));
		else if (t_s3 <= (ONE_T << 1))
			kw = -$signed((T_W+8)'(t3_s3)) + 5 * $signed((T_W+8)'(t2_s3)) -
				($signed((T_W+8)'(t_s3)) <<< 3) + ($signed((T_W+8)'(ONE_T)) <<< 2);
		else
			kw = '0;
		wnew = bilinear ? $signed(W_W'(bw_s3)) : W_W'(kw);
	end

	always_ff @(posedge clk) begin
		if (wv_s3) begin
			if (widx_s3[2])
				wy_q[widx_s3[1:0]] <= wnew;
			else
				wx_q[widx_s3[1:0]] <= wnew;
		end
	end

	// tap mac pipe: fetch, weight product, row sum, row weight product, total
	logic                       tv_s1, tv_s2, rv_s3;
	logic                       oob_s1, last_s1, last_s2;
	logic [1:0]                 i_s1, j_s1, j_s2, j_s3;
	logic signed [SAMPLE_W-1:0] center_q, tap_val;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [LINE_W-1:0]   line_q, line_sum, line_init, row_s3;
	logic signed [OPROD_W-1:0]  oprod_s4;
	logic                       ov_s4;
	logic signed [ACC_W-1:0]    acc_q, acc_init;

	assign line_init = bicubic ? (LINE_W'(1) <<< (FRAC - 1)) : '0;
	assign acc_init  = bicubic ? (ACC_W'(1) <<< (FRAC - 1)) : (ACC_W'(1) <<< (2*FRAC - 1));
	assign tap_val   = oob_s1 ? center_q : mem_q;
	assign line_sum  = line_q + LINE_W'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_s1 <= 1'b0;
			tv_s2 <= 1'b0;
			rv_s3 <= 1'b0;
			ov_s4 <= 1'b0;
		end else begin
			tv_s1 <= cmd.tap_issue;
			tv_s2 <= tv_s1;
			rv_s3 <= tv_s2 & last_s2;
			ov_s4 <= rv_s3;
		end
	end

	always_ff @(posedge clk) begin
		oob_s1   <= tap_oob;
		last_s1  <= tap_last;
		i_s1     <= tap_i;
		j_s1     <= tap_j;
		prod_s2  <= wx_q[i_s1] * tap_val;
		last_s2  <= last_s1;
		j_s2     <= j_s1;
		j_s3     <= j_s2;
		oprod_s4 <= wy_q[j_s3] * row_s3;
		if (cmd.blend_init) begin
			center_q <= mem_q;
			line_q   <= line_init;
			acc_q    <= acc_init;
		end else begin
			if (tv_s2) begin
				if (last_s2) begin
					row_s3 <= bicubic ? (line_sum >>> FRAC) : line_sum;
					line_q <= line_init;
				end else begin
					line_q <= line_sum;
				end
			end
			if (ov_s4)
				acc_q <= acc_q + ACC_W'(oprod_s4);
		end
	end

	// final shift and saturation
	logic signed [ACC_W-1:0]    blend_full;
	logic signed [SAMPLE_W-1:0] blend_sat;
	logic [ACC_W-SAMPLE_W:0]    upper;

	always_comb begin
		blend_full = bicubic ? (acc_q >>> FRAC) : (acc_q >>> (2*FRAC));
		upper      = blend_full[ACC_W-1:SAMPLE_W-1];
		if ((&upper) || !(|upper))
			blend_sat = blend_full[SAMPLE_W-1:0];
		else
			blend_sat = {blend_full[ACC_W-1], {(SAMPLE_W-1){~blend_full[ACC_W-1]}}};
	end

	// result register, shown for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= cmd.fin;
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			case (cmd.sel)
				RES_ZERO: begin
					result_value <= '0;
					no_data      <= 1'b0;
					edge_clamped <= 1'b0;
				end
				RES_NODATA: begin
					result_value <= cfg.nodata_value;
					no_data      <= 1'b1;
					edge_clamped <= 1'b0;
				end
				RES_CENTER: begin
					result_value <= mem_q;
					no_data      <= 1'b0;
					edge_clamped <= cmd.clamp_flag;
				end
				default: begin
					result_value <= blend_sat;
					no_data      <= 1'b0;
					edge_clamped <= 1'b0;
				end
			endcase
		end
	end

endmodule

@@ src/raster_resampler.sv @@
// ----------------------------------------------------------------------------
// raster_resampler
// multi-band raster store with nearest, bilinear and bicubic sampling
// ----------------------------------------------------------------------------
// usage
//  - a transaction is taken at a rising edge with start high and busy low;
//    operation selects a sample write or a sample query at a map position
//  - each transaction gives exactly one result, shown for one cycle with done
//    high; the receiver cannot stall, so it must take it in that cycle
//  - the next transaction may be started in the done cycle
//  - the two cell mapping dividers give one quotient bit per cycle over 56
//    integer and fraction bits, and the single store read port fetches one
//    tap per cycle, so those two set the query time
//  - configuration is written through the apb-style port while idle; all
//    registers live at 8-byte spacing
//  - reset clears control state and restores register defaults; the store
//    itself is not cleared and reads back undefined until written
// ----------------------------------------------------------------------------
module raster_resampler (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// item channel
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 operation,
	input  logic [7:0]                           write_row,
	input  logic [7:0]                           write_column,
	input  logic                                 band_index,
	input  logic signed [31:0]                   write_value,
	input  logic signed [39:0]                   position_x,
	input  logic signed [39:0]                   position_y,
	// result channel
	output logic                                 done,
	output logic signed [31:0]                   result_value,
	output logic                                 no_data,
	output logic                                 edge_clamped,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [rres_pkg::PADDR_W-1:0]         paddr,
	input  logic [rres_pkg::PDATA_W-1:0]         pwdata,
	output logic [rres_pkg::PDATA_W-1:0]         prdata,
	output logic                                 pready
);
	import rres_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// zero wait state register access
	assign pready = 1'b1;

	rres_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// sequencer owns the state, datapath owns every value
	rres_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.sts       (sts),
		.cmd       (cmd),
		.busy      (busy)
	);

	rres_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.sts          (sts),
		.write_row    (write_row),
		.write_column (write_column),
		.band_index   (band_index),
		.write_value  (write_value),
		.position_x   (position_x),
		.position_y   (position_y),
		.done         (done),
		.result_value (result_value),
		.no_data      (no_data),
		.edge_clamped (edge_clamped)
	);

endmodule

@@ src/rres_checker.sv @@
// ----------------------------------------------------------------------------
// rres_checker
// port-level checks on the item and result channels
// ----------------------------------------------------------------------------
module rres_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic no_data,
	input logic edge_clamped
);

	// an accepted transaction keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted transaction did not raise busy");

	// the result is shown once the work is done
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// one transaction gives one strobe
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// no-data and clamped edge are exclusive
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(no_data && edge_clamped))
		else $error("no_data and edge_clamped both set");

endmodule

bind raster_resampler rres_checker u_rres_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.no_data      (no_data),
	.edge_clamped (edge_clamped)
);
